@@ rtl/mkld_pkg.sv @@
// Package for the multi-key lockout debouncer.
// Holds the key count, field widths, register map and the event encoder.
// No dependencies.
package mkld_pkg;

    localparam int NUM_KEYS   = 14;
    localparam int TIME_WIDTH = 32;
    localparam int KEY_IDX_W  = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_LOCKOUT    = 1'b0;
    localparam logic REG_ACTIVE_LOW = 1'b1;

    localparam logic [TIME_WIDTH-1:0] LOCKOUT_RESET = TIME_WIDTH'(3000100);

    typedef logic [NUM_KEYS-1:0]   t_keys;
    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [KEY_IDX_W-1:0]  t_key_idx;

    typedef struct packed {
        t_time lockout_ticks;
        logic  active_low;
    } t_cfg;

    // lowest set key in a mask
    function automatic t_key_idx lowest_key(input t_keys mask);
        t_key_idx idx;
        idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = KEY_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/mkld_cfg.sv @@
// Configuration registers of the debouncer on an APB-style port.
// Depends on mkld_pkg for the register map and the t_cfg struct.
module mkld_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkld_pkg::ADDR_W-1:0]   paddr,
    input  logic [mkld_pkg::DATA_W-1:0]   pwdata,
    output logic [mkld_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mkld_pkg::t_cfg                o_cfg
);
    import mkld_pkg::*;

    t_time r_lockout, n_lockout;
    logic  r_active_low, n_active_low;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // decode the write
    always_comb begin
        n_lockout    = r_lockout;
        n_active_low = r_active_low;
        if (wr_en) begin
            case (paddr[2])
                REG_LOCKOUT:    n_lockout    = pwdata[TIME_WIDTH-1:0];
                REG_ACTIVE_LOW: n_active_low = pwdata[0];
                default: ;
            endcase
        end
    end

    // hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout    <= LOCKOUT_RESET;
            r_active_low <= 1'b1;
        end else begin
            r_lockout    <= n_lockout;
            r_active_low <= n_active_low;
        end
    end

    // return the addressed register
    always_comb begin
        case (paddr[2])
            REG_LOCKOUT:    prdata = DATA_W'(r_lockout);
            REG_ACTIVE_LOW: prdata = DATA_W'(r_active_low);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.lockout_ticks = r_lockout;
    assign o_cfg.active_low    = r_active_low;

endmodule

@@ rtl/mkld_lane.sv @@
// One key lane: edge test against the lockout window and the key's time stamp.
// Depends on mkld_pkg for the time width.
module mkld_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_level,
    input  logic            i_prev,
    input  mkld_pkg::t_time i_now,
    input  mkld_pkg::t_time i_lockout,
    output logic            o_fire
);
    import mkld_pkg::*;

    t_time r_stamp, n_stamp;
    t_time elapsed;

    // wrapped elapsed time of a down-counting timer
    assign elapsed = r_stamp - i_now;
    assign o_fire  = (i_level ^ i_prev) && (elapsed >= i_lockout);

    // refresh the stamp on an accepted edge
    always_comb begin
        n_stamp = r_stamp;
        if (i_accept && o_fire) begin
            n_stamp = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else begin
            r_stamp <= n_stamp;
        end
    end

endmodule

@@ rtl/mkld_merge.sv @@
// Merging stage: holds the fired-key mask and sends one event word per key,
// lowest key first. Depends on mkld_pkg for the key types and encoder.
module mkld_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mkld_pkg::t_keys    i_mask,
    input  mkld_pkg::t_keys    i_levels,
    input  logic               i_stall,
    output logic               o_valid,
    output mkld_pkg::t_key_idx o_key_id,
    output logic               o_pressed,
    output logic               o_last_event,
    output logic               o_busy
);
    import mkld_pkg::*;

    t_keys r_mask, n_mask;
    t_keys r_levels;
    t_keys rest;
    logic  pop;

    assign o_valid      = |r_mask;
    assign o_key_id     = lowest_key(r_mask);
    assign o_pressed    = r_levels[o_key_id];
    assign rest         = r_mask & (r_mask - t_keys'(1));
    assign o_last_event = (rest == '0);
    assign pop          = o_valid && !i_stall;
    // busy until the final word of the held mask leaves
    assign o_busy       = o_valid && !(pop && o_last_event);

    // load a new mask or drop the lowest key
    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_mask;
        end else if (pop) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // hold the sample levels for the press flags
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_levels <= i_levels;
        end
    end

endmodule

@@ rtl/multi_key_lockout_debouncer.sv @@
// Multi-key lockout debouncer, top level.
// The first event word of a sample is valid in the cycle after the sample is accepted.
// Throughput: one event word per cycle while i_stall is low; the merging stage sends the keys
// one at a time and stalls input until the last event word of a sample leaves.
// Reset: synchronous, active low; clears previous levels, stamps and pending events,
// and loads lockout_ticks = 3000100 and active_low = 1.
module multi_key_lockout_debouncer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [13:0]                   i_key_levels,
    input  logic [31:0]                   i_time_now,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [3:0]                    o_key_id,
    output logic                          o_pressed,
    output logic                          o_last_event,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkld_pkg::ADDR_W-1:0]   paddr,
    input  logic [mkld_pkg::DATA_W-1:0]   pwdata,
    output logic [mkld_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mkld_pkg::*;

    t_cfg  cfg;
    t_keys r_prev;
    t_keys levels;
    t_keys fire;
    logic  in_accept;
    logic  busy;

    mkld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // normalize so a pressed key reads 1
    assign levels    = t_keys'(i_key_levels) ^ {NUM_KEYS{cfg.active_low}};
    assign o_stall   = busy;
    assign in_accept = i_valid && !busy;

    // one lane per key
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        mkld_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (in_accept),
            .i_level   (levels[k]),
            .i_prev    (r_prev[k]),
            .i_now     (t_time'(i_time_now)),
            .i_lockout (cfg.lockout_ticks),
            .o_fire    (fire[k])
        );
    end

    // store the levels of every accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (in_accept) begin
            r_prev <= levels;
        end
    end

    mkld_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_accept),
        .i_mask       (fire),
        .i_levels     (levels),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_key_id     (o_key_id),
        .o_pressed    (o_pressed),
        .o_last_event (o_last_event),
        .o_busy       (busy)
    );

endmodule

@@ rtl/mkld_checker.sv @@
// Port-level checker for the debouncer, bound to the top level.
// Depends on mkld_pkg for the port widths and key count.
module mkld_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [3:0]                    o_key_id,
    input logic                          o_pressed,
    input logic                          o_last_event
);
    import mkld_pkg::*;

    // hold a stalled event word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_id)
            && $stable(o_pressed) && $stable(o_last_event))
        else $error("stalled event word changed");

    // advance to a higher key until the last word of a sample
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_event |=> o_valid
            && (o_key_id > $past(o_key_id)))
        else $error("events of one sample out of order or lost");

    // stall input while more words of a sample remain
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_event |-> o_stall)
        else $error("new sample taken with events pending");

    // drop stall when nothing is pending
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall with no pending event");

    // key number stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_id < 4'(NUM_KEYS)))
        else $error("key number out of range");

endmodule

bind multi_key_lockout_debouncer mkld_checker u_mkld_checker (.*);
